### sv/least_cost_transport_allocator_unit_assert.svh
// ---------------------------------------------------------------------------
// Least-cost transport allocator assertion macros
// Concurrent assertion helpers, empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef LEAST_COST_TRANSPORT_ALLOCATOR_UNIT_ASSERT_SVH
`define LEAST_COST_TRANSPORT_ALLOCATOR_UNIT_ASSERT_SVH
`ifndef SYNTH
`define LCTA_ASSERT_ALWAYS(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("allocator assertion failed");
`define LCTA_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("allocator assertion failed");
`else
`define LCTA_ASSERT_ALWAYS(lbl, expr)
`define LCTA_ASSERT_IMPLY(lbl, ante, cons)
`endif
`endif

### sv/lcta_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Least-cost transport allocator package
// Widths, limits and operation codes shared by the allocator.
// ---------------------------------------------------------------------------
package lcta_pkg;
   localparam int SIDE_W   = 6;
   localparam int CNT_W    = SIDE_W + 1;
   localparam int CELL_W   = 2 * SIDE_W;
   localparam int AMT_W    = 22;
   localparam int COST_W   = 10;
   localparam int TOTAL_W  = 32;
   localparam int VALUE_W  = 16;
   localparam int OP_W     = 3;
   localparam int REQ_W    = 32;
   localparam int RSP_W    = 72;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 6;
   localparam logic [COST_W-1:0] COST_LIMIT = 10'd1000;
   localparam logic [COST_W-1:0] COST_MAX   = 10'd1023;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD_COST   = 3'd0,
      OP_LOAD_SUPPLY = 3'd1,
      OP_LOAD_DEMAND = 3'd2,
      OP_SOLVE       = 3'd3,
      OP_READ        = 3'd4
   } op_type;

   localparam logic [CSR_IDX_W-1:0] CSR_SUPPLY_COUNT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEMAND_COUNT = 1'd1;

   localparam logic [1:0] BAL_NONE = 2'd0;
   localparam logic [1:0] BAL_COL  = 2'd1;
   localparam logic [1:0] BAL_ROW  = 2'd2;
   localparam logic [1:0] LEFT_NONE = 2'd0;
   localparam logic [1:0] LEFT_COL  = 2'd1;
   localparam logic [1:0] LEFT_ROW  = 2'd2;
   localparam logic [1:0] LEFT_STAY = 2'd3;
endpackage

### sv/least_cost_transport_allocator_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Least-cost transport allocator
// Loads costs, supplies and demands, solves by the least-cost method and
// returns per-cell allocations.
// ---------------------------------------------------------------------------
// Requests enter on req_ (stream slave), results leave on rsp_ (stream
// master); csr_ sets the supply and demand counts; the user writes it only
// while idle, and the block itself does not enforce this. Load requests are
// written on acceptance and give no result. A read request passes through a
// read state that registers its result; the block takes the next request
// only once it is back in idle. A solve request first clears all 4096
// allocation words while summing supplies and demands, balances, then runs
// greedy scans over the cost and allocation memories; each chosen cell is
// shipped and adds one more scan. When supply or demand is left, a leftover
// check and possibly a fill follow; a final cost pass and a done state come
// last, and the result is then presented. Each memory has one read port.
// One request is worked on at a time; a request is taken when the block is
// idle and the result register is empty or being emptied. When rsp_tready
// is low the result holds in its register. Reset empties the block; reads
// before the first solve return zero.
// ---------------------------------------------------------------------------
module least_cost_transport_allocator_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // operation[2:0], row[8:3], col[14:9], value[30:15], zero[31]
   input  logic [lcta_pkg::REQ_W-1:0]           req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // shipped_amount[21:0], total_cost[53:22], balance_kind[55:54],
   // leftover_kind[57:56], rows_used[64:58], cols_used[71:65]
   output logic [lcta_pkg::RSP_W-1:0]           rsp_tdata,
   input  logic                                 csr_we,
   input  logic [lcta_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lcta_pkg::CSR_DAT_W-1:0]       csr_wdata
);
   import lcta_pkg::*;
   `include "least_cost_transport_allocator_unit_assert.svh"

   typedef enum logic [3:0] {
      ST_IDLE, ST_READ, ST_CLEAR, ST_BAL, ST_SCAN, ST_PICK, ST_SHIP,
      ST_CHECK, ST_FILL, ST_COST, ST_DONE
   } state_type;

   state_type           state_ff;
   logic [SIDE_W-1:0]   sup_cnt_ff, dem_cnt_ff;
   logic [CNT_W-1:0]    m_ff, n_ff;
   logic [1:0]          kind_ff, left_ff;
   logic [AMT_W-1:0]    sup_tot_ff, dem_tot_ff;
   logic [CELL_W-1:0]   clr_ff;
   logic [SIDE_W-1:0]   i_ff, j_ff, pi_ff, pj_ff, si_ff;
   logic                vld_ff, pvld_ff, sum_vld_ff, issued_ff, phase_ff;
   logic [COST_W-1:0]   best_ff;
   logic                found_ff;
   logic [SIDE_W-1:0]   bi_ff, bj_ff;
   logic                rows_clr_ff, cols_clr_ff, solved_ff;
   logic [TOTAL_W-1:0]  prod_ff, total_ff;
   logic                rsp_valid_ff;
   logic [RSP_W-1:0]    rsp_data_ff;

   // memories
   logic [COST_W-1:0]   cost_mem [0:(1<<CELL_W)-1];
   logic [AMT_W:0]      alloc_mem [0:(1<<CELL_W)-1];
   logic [AMT_W-1:0]    sup_mem [0:(1<<SIDE_W)-1];
   logic [AMT_W-1:0]    dem_mem [0:(1<<SIDE_W)-1];
   logic [COST_W-1:0]   cost_rd_ff;
   logic [AMT_W:0]      alloc_rd_ff;
   logic [AMT_W-1:0]    sup_rd_ff, dem_rd_ff;

   logic [CELL_W-1:0]   cost_ra, cost_wa, alloc_ra, alloc_wa;
   logic                cost_we, alloc_we, sup_we, dem_we;
   logic [COST_W-1:0]   cost_wd;
   logic [AMT_W:0]      alloc_wd;
   logic [SIDE_W-1:0]   sup_ra, dem_ra, sup_wa, dem_wa;
   logic [AMT_W-1:0]    sup_wd, dem_wd;

   logic [OP_W-1:0]     req_op;
   logic [SIDE_W-1:0]   req_row, req_col;
   logic [VALUE_W-1:0]  req_val;
   logic                req_fire;
   logic [SIDE_W-1:0]   m_last, n_last;
   logic                cell_last, line_last;
   logic [SIDE_W-1:0]   fill_row, fill_col;
   logic                eval_dummy;
   logic [COST_W-1:0]   eval_cost;
   logic [AMT_W-1:0]    ship_q, fill_sum;

   assign req_op   = req_tdata[OP_W-1:0];
   assign req_row  = req_tdata[OP_W+SIDE_W-1:OP_W];
   assign req_col  = req_tdata[OP_W+2*SIDE_W-1:OP_W+SIDE_W];
   assign req_val  = req_tdata[OP_W+2*SIDE_W+VALUE_W-1:OP_W+2*SIDE_W];
   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_fire = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign m_last    = SIDE_W'(m_ff - CNT_W'(1));
   assign n_last    = SIDE_W'(n_ff - CNT_W'(1));
   assign cell_last = (i_ff == m_last) && (j_ff == n_last);
   assign line_last = (left_ff == LEFT_ROW) ? (i_ff == n_last) : (i_ff == m_last);
   assign fill_row  = (left_ff == LEFT_ROW) ? m_last : i_ff;
   assign fill_col  = (left_ff == LEFT_ROW) ? i_ff : n_last;
   assign eval_dummy = ((kind_ff == BAL_COL) && (pj_ff == n_last))
                    || ((kind_ff == BAL_ROW) && (pi_ff == m_last));
   assign eval_cost = eval_dummy ? '0 : cost_rd_ff;
   assign ship_q    = (sup_rd_ff < dem_rd_ff) ? sup_rd_ff : dem_rd_ff;
   assign fill_sum  = alloc_rd_ff[AMT_W-1:0]
                    + ((left_ff == LEFT_ROW) ? dem_rd_ff : sup_rd_ff);

   // memory port selection
   always_comb begin
      cost_ra  = {i_ff, j_ff};
      alloc_ra = {i_ff, j_ff};
      sup_ra   = i_ff;
      dem_ra   = i_ff;
      cost_we  = 1'b0;
      cost_wa  = {req_row, req_col};
      cost_wd  = (req_val > VALUE_W'(COST_MAX)) ? COST_MAX : req_val[COST_W-1:0];
      alloc_we = 1'b0;
      alloc_wa = clr_ff;
      alloc_wd = '0;
      sup_we   = 1'b0;
      sup_wa   = req_row;
      sup_wd   = AMT_W'(req_val);
      dem_we   = 1'b0;
      dem_wa   = req_col;
      dem_wd   = AMT_W'(req_val);
      case (state_ff)
         ST_IDLE: begin
            alloc_ra = {req_row, req_col};
            if (req_fire) begin
               cost_we = (req_op == OP_LOAD_COST);
               sup_we  = (req_op == OP_LOAD_SUPPLY);
               dem_we  = (req_op == OP_LOAD_DEMAND);
            end
         end
         ST_CLEAR: begin
            alloc_we = 1'b1;
            sup_ra   = clr_ff[SIDE_W-1:0];
            dem_ra   = clr_ff[SIDE_W-1:0];
         end
         ST_BAL: begin
            sup_wa = m_ff[SIDE_W-1:0];
            sup_wd = dem_tot_ff - sup_tot_ff;
            sup_we = (sup_tot_ff < dem_tot_ff);
            dem_wa = n_ff[SIDE_W-1:0];
            dem_wd = sup_tot_ff - dem_tot_ff;
            dem_we = (sup_tot_ff > dem_tot_ff);
         end
         ST_PICK: begin
            sup_ra = bi_ff;
            dem_ra = bj_ff;
         end
         ST_SHIP: begin
            alloc_we = 1'b1;
            alloc_wa = {bi_ff, bj_ff};
            alloc_wd = {1'b1, ship_q};
            sup_we   = 1'b1;
            sup_wa   = bi_ff;
            sup_wd   = sup_rd_ff - ship_q;
            dem_we   = 1'b1;
            dem_wa   = bj_ff;
            dem_wd   = dem_rd_ff - ship_q;
         end
         ST_FILL: begin
            alloc_ra = {fill_row, fill_col};
            alloc_wa = {fill_row, fill_col};
            alloc_wd = {alloc_rd_ff[AMT_W], fill_sum};
            alloc_we = phase_ff;
            sup_wd   = '0;
            dem_wd   = '0;
            sup_we   = phase_ff;
            dem_we   = phase_ff;
            sup_wa   = (left_ff == LEFT_ROW) ? m_last : i_ff;
            dem_wa   = (left_ff == LEFT_ROW) ? i_ff : n_last;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cost_we) begin
         cost_mem[cost_wa] <= cost_wd;
      end
      cost_rd_ff <= cost_mem[cost_ra];
   end

   always_ff @(posedge clock) begin
      if (alloc_we) begin
         alloc_mem[alloc_wa] <= alloc_wd;
      end
      alloc_rd_ff <= alloc_mem[alloc_ra];
   end

   always_ff @(posedge clock) begin
      if (sup_we) begin
         sup_mem[sup_wa] <= sup_wd;
      end
      sup_rd_ff <= sup_mem[sup_ra];
   end

   always_ff @(posedge clock) begin
      if (dem_we) begin
         dem_mem[dem_wa] <= dem_wd;
      end
      dem_rd_ff <= dem_mem[dem_ra];
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sup_cnt_ff   <= SIDE_W'(1);
         dem_cnt_ff   <= SIDE_W'(1);
         m_ff         <= CNT_W'(1);
         n_ff         <= CNT_W'(1);
         kind_ff      <= BAL_NONE;
         left_ff      <= LEFT_NONE;
         sup_tot_ff   <= '0;
         dem_tot_ff   <= '0;
         clr_ff       <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         vld_ff       <= 1'b0;
         pvld_ff      <= 1'b0;
         sum_vld_ff   <= 1'b0;
         issued_ff    <= 1'b0;
         phase_ff     <= 1'b0;
         best_ff      <= COST_LIMIT;
         found_ff     <= 1'b0;
         rows_clr_ff  <= 1'b1;
         cols_clr_ff  <= 1'b1;
         solved_ff    <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we && (csr_index == CSR_SUPPLY_COUNT)) begin
            sup_cnt_ff <= csr_wdata;
         end
         if (csr_we && (csr_index == CSR_DEMAND_COUNT)) begin
            dem_cnt_ff <= csr_wdata;
         end
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         pi_ff <= i_ff;
         pj_ff <= j_ff;
         case (state_ff)
            ST_IDLE: begin
               if (req_fire && (req_op == OP_READ)) begin
                  state_ff <= ST_READ;
               end else if (req_fire && (req_op == OP_SOLVE)) begin
                  state_ff   <= ST_CLEAR;
                  solved_ff  <= 1'b1;
                  clr_ff     <= '0;
                  sup_tot_ff <= '0;
                  dem_tot_ff <= '0;
                  sum_vld_ff <= 1'b0;
                  m_ff <= (sup_cnt_ff == '0) ? CNT_W'(1) : CNT_W'(sup_cnt_ff);
                  n_ff <= (dem_cnt_ff == '0) ? CNT_W'(1) : CNT_W'(dem_cnt_ff);
               end
            end
            ST_READ: begin
               rsp_valid_ff <= 1'b1;
               rsp_data_ff  <= {{(RSP_W-AMT_W){1'b0}},
                                (solved_ff ? alloc_rd_ff[AMT_W-1:0] : {AMT_W{1'b0}})};
               state_ff     <= ST_IDLE;
            end
            ST_CLEAR: begin
               // sum supplies and demands while sweeping the allocations
               sum_vld_ff <= (clr_ff[CELL_W-1:SIDE_W] == '0);
               si_ff      <= clr_ff[SIDE_W-1:0];
               if (sum_vld_ff && (CNT_W'(si_ff) < m_ff)) begin
                  sup_tot_ff <= sup_tot_ff + sup_rd_ff;
               end
               if (sum_vld_ff && (CNT_W'(si_ff) < n_ff)) begin
                  dem_tot_ff <= dem_tot_ff + dem_rd_ff;
               end
               clr_ff <= clr_ff + CELL_W'(1);
               if (clr_ff == '1) begin
                  state_ff <= ST_BAL;
               end
            end
            ST_BAL: begin
               if (sup_tot_ff > dem_tot_ff) begin
                  kind_ff    <= BAL_COL;
                  dem_tot_ff <= sup_tot_ff;
                  n_ff       <= n_ff + CNT_W'(1);
               end else if (sup_tot_ff < dem_tot_ff) begin
                  kind_ff    <= BAL_ROW;
                  sup_tot_ff <= dem_tot_ff;
                  m_ff       <= m_ff + CNT_W'(1);
               end else begin
                  kind_ff <= BAL_NONE;
               end
               left_ff   <= LEFT_NONE;
               state_ff  <= ST_SCAN;
               i_ff      <= '0;
               j_ff      <= '0;
               issued_ff <= 1'b0;
               vld_ff    <= 1'b0;
               best_ff   <= COST_LIMIT;
               found_ff  <= 1'b0;
            end
            ST_SCAN: begin
               vld_ff <= !issued_ff;
               if (!issued_ff) begin
                  if (cell_last) begin
                     issued_ff <= 1'b1;
                  end else if (j_ff == n_last) begin
                     j_ff <= '0;
                     i_ff <= i_ff + SIDE_W'(1);
                  end else begin
                     j_ff <= j_ff + SIDE_W'(1);
                  end
               end
               if (vld_ff && !alloc_rd_ff[AMT_W] && (eval_cost != '0)
                   && (eval_cost < best_ff)) begin
                  best_ff  <= eval_cost;
                  bi_ff    <= pi_ff;
                  bj_ff    <= pj_ff;
                  found_ff <= 1'b1;
               end
               if (issued_ff && !vld_ff) begin
                  i_ff      <= '0;
                  j_ff      <= '0;
                  issued_ff <= 1'b0;
                  if (found_ff) begin
                     state_ff <= ST_PICK;
                  end else if ((sup_tot_ff != '0) || (dem_tot_ff != '0)) begin
                     state_ff    <= ST_CHECK;
                     rows_clr_ff <= 1'b1;
                     cols_clr_ff <= 1'b1;
                  end else begin
                     state_ff <= ST_COST;
                     total_ff <= '0;
                     pvld_ff  <= 1'b0;
                  end
               end
            end
            ST_PICK: begin
               state_ff <= ST_SHIP;
            end
            ST_SHIP: begin
               sup_tot_ff <= sup_tot_ff - ship_q;
               dem_tot_ff <= dem_tot_ff - ship_q;
               best_ff    <= COST_LIMIT;
               found_ff   <= 1'b0;
               vld_ff     <= 1'b0;
               state_ff   <= ST_SCAN;
            end
            ST_CHECK: begin
               vld_ff <= !issued_ff;
               if (!issued_ff) begin
                  i_ff <= i_ff + SIDE_W'(1);
                  if (i_ff == '1) begin
                     issued_ff <= 1'b1;
                  end
               end
               if (vld_ff && ((CNT_W'(pi_ff) + CNT_W'(1)) < m_ff) && (sup_rd_ff != '0)) begin
                  rows_clr_ff <= 1'b0;
               end
               if (vld_ff && ((CNT_W'(pi_ff) + CNT_W'(1)) < n_ff) && (dem_rd_ff != '0)) begin
                  cols_clr_ff <= 1'b0;
               end
               if (issued_ff && !vld_ff) begin
                  i_ff      <= '0;
                  issued_ff <= 1'b0;
                  phase_ff  <= 1'b0;
                  if (rows_clr_ff) begin
                     left_ff  <= LEFT_ROW;
                     state_ff <= ST_FILL;
                  end else if (cols_clr_ff) begin
                     left_ff  <= LEFT_COL;
                     state_ff <= ST_FILL;
                  end else begin
                     left_ff  <= LEFT_STAY;
                     state_ff <= ST_COST;
                     total_ff <= '0;
                     pvld_ff  <= 1'b0;
                  end
               end
            end
            ST_FILL: begin
               phase_ff <= !phase_ff;
               if (phase_ff) begin
                  if (line_last) begin
                     sup_tot_ff <= '0;
                     dem_tot_ff <= '0;
                     i_ff       <= '0;
                     j_ff       <= '0;
                     state_ff   <= ST_COST;
                     total_ff   <= '0;
                     pvld_ff    <= 1'b0;
                     vld_ff     <= 1'b0;
                  end else begin
                     i_ff <= i_ff + SIDE_W'(1);
                  end
               end
            end
            ST_COST: begin
               vld_ff  <= !issued_ff;
               pvld_ff <= vld_ff;
               if (!issued_ff) begin
                  if (cell_last) begin
                     issued_ff <= 1'b1;
                  end else if (j_ff == n_last) begin
                     j_ff <= '0;
                     i_ff <= i_ff + SIDE_W'(1);
                  end else begin
                     j_ff <= j_ff + SIDE_W'(1);
                  end
               end
               prod_ff <= TOTAL_W'(alloc_rd_ff[AMT_W-1:0]) * TOTAL_W'(eval_cost);
               if (pvld_ff) begin
                  total_ff <= total_ff + prod_ff;
               end
               if (issued_ff && !vld_ff && !pvld_ff) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               rsp_valid_ff <= 1'b1;
               rsp_data_ff  <= {n_ff, m_ff, left_ff, kind_ff, total_ff, {AMT_W{1'b0}}};
               state_ff     <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   `LCTA_ASSERT_IMPLY(a_pick_found, state_ff == ST_PICK, found_ff)
   `LCTA_ASSERT_IMPLY(a_balanced, (state_ff == ST_SCAN) || (state_ff == ST_PICK) || (state_ff == ST_SHIP), sup_tot_ff == dem_tot_ff)
   `LCTA_ASSERT_ALWAYS(a_best_limit, best_ff <= COST_LIMIT)
   `LCTA_ASSERT_ALWAYS(a_sizes, (m_ff != '0) && (n_ff != '0))
endmodule
